@@ src/twofish_block_encrypt_core_assert.svh @@
// Assertion macros for the Twofish encryption core.
// Used by the top level only; no other dependencies.
`ifndef TWOFISH_BLOCK_ENCRYPT_CORE_ASSERT_SVH
`define TWOFISH_BLOCK_ENCRYPT_CORE_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define TF_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("twofish core assertion failed");

// antecedent implies consequent in the next cycle
`define TF_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("twofish core assertion failed");

`endif

@@ src/twofish_pkg.sv @@
// Shared types, constants and GF(2^8)/q-permutation functions for the
// Twofish encryption core. No dependencies.
`timescale 1ns / 1ps
package twofish_pkg;

  localparam int ROUND_COUNT  = 16;
  localparam int SUBKEY_PAIRS = 4 + ROUND_COUNT;
  localparam int PAIR_AW      = $clog2(SUBKEY_PAIRS);

  localparam logic [7:0] MDS_POLY = 8'h69;
  localparam logic [7:0] RS_POLY  = 8'h4D;

  typedef logic [3:0][31:0] word4_t;

  typedef enum logic [2:0] {
    CFG_KEY0     = 3'd0,
    CFG_KEY1     = 3'd1,
    CFG_KEY2     = 3'd2,
    CFG_KEY3     = 3'd3,
    CFG_KEY_SIZE = 3'd4
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE, ST_RS, ST_KS_A, ST_KS_B, ST_WIN0, ST_WIN1, ST_WIN2,
    ST_RND_A, ST_RND_B, ST_WOUT0, ST_WOUT1, ST_WOUT2
  } state_e;

  localparam logic [3:0] Q0T [4][16] = '{
    '{4'h8,4'h1,4'h7,4'hD,4'h6,4'hF,4'h3,4'h2,4'h0,4'hB,4'h5,4'h9,4'hE,4'hC,4'hA,4'h4},
    '{4'hE,4'hC,4'hB,4'h8,4'h1,4'h2,4'h3,4'h5,4'hF,4'h4,4'hA,4'h6,4'h7,4'h0,4'h9,4'hD},
    '{4'hB,4'hA,4'h5,4'hE,4'h6,4'hD,4'h9,4'h0,4'hC,4'h8,4'hF,4'h3,4'h2,4'h4,4'h7,4'h1},
    '{4'hD,4'h7,4'hF,4'h4,4'h1,4'h2,4'h6,4'hE,4'h9,4'hB,4'h3,4'h0,4'h8,4'h5,4'hC,4'hA}
  };

  localparam logic [3:0] Q1T [4][16] = '{
    '{4'h2,4'h8,4'hB,4'hD,4'hF,4'h7,4'h6,4'hE,4'h3,4'h1,4'h9,4'h4,4'h0,4'hA,4'hC,4'h5},
    '{4'h1,4'hE,4'h2,4'hB,4'h4,4'hC,4'h3,4'h7,4'h6,4'hD,4'hA,4'h5,4'hF,4'h9,4'h0,4'h8},
    '{4'h4,4'hC,4'h7,4'h5,4'h1,4'h6,4'h9,4'hA,4'h0,4'hE,4'hD,4'h8,4'h2,4'hB,4'h3,4'hF},
    '{4'hB,4'h9,4'h5,4'h1,4'hC,4'h3,4'hD,4'hE,4'h6,4'h4,4'h7,4'hF,4'h2,4'h0,4'h8,4'hA}
  };

  localparam logic [7:0] MDS_M [4][4] = '{
    '{8'h01, 8'hEF, 8'h5B, 8'h5B},
    '{8'h5B, 8'hEF, 8'hEF, 8'h01},
    '{8'hEF, 8'h5B, 8'h01, 8'hEF},
    '{8'hEF, 8'h01, 8'hEF, 8'h5B}
  };

  localparam logic [7:0] RS_M [4][8] = '{
    '{8'h01, 8'hA4, 8'h55, 8'h87, 8'h5A, 8'h58, 8'hDB, 8'h9E},
    '{8'hA4, 8'h56, 8'h82, 8'hF3, 8'h1E, 8'hC6, 8'h68, 8'hE5},
    '{8'h02, 8'hA1, 8'hFC, 8'hC1, 8'h47, 8'hAE, 8'h3D, 8'h19},
    '{8'hA4, 8'h55, 8'h87, 8'h5A, 8'h58, 8'hDB, 8'h9E, 8'h03}
  };

  function automatic logic [7:0] gf_mul(logic [7:0] a, logic [7:0] b, logic [7:0] poly);
    logic [7:0] r;
    logic [7:0] aa;
    r  = 8'h00;
    aa = a;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) r = r ^ aa;
      aa = aa[7] ? ({aa[6:0], 1'b0} ^ poly) : {aa[6:0], 1'b0};
    end
    return r;
  endfunction

  function automatic logic [3:0] ror4(logic [3:0] x);
    return {x[0], x[3:1]};
  endfunction

  function automatic logic [7:0] qperm(logic which, logic [7:0] x);
    logic [3:0] a0, b0, a1, b1, a2, b2, a3, b3, lo, hi;
    a0 = x[7:4];
    b0 = x[3:0];
    a1 = a0 ^ b0;
    b1 = a0 ^ ror4(b0) ^ {a0[0], 3'b000};
    a2 = which ? Q1T[0][a1] : Q0T[0][a1];
    b2 = which ? Q1T[1][b1] : Q0T[1][b1];
    a3 = a2 ^ b2;
    b3 = a2 ^ ror4(b2) ^ {a2[0], 3'b000};
    lo = which ? Q1T[2][a3] : Q0T[2][a3];
    hi = which ? Q1T[3][b3] : Q0T[3][b3];
    return {hi, lo};
  endfunction

  // one S-box key word from eight key bytes
  function automatic logic [31:0] rs_word(logic [63:0] kw);
    logic [31:0] s;
    logic [7:0]  v;
    s = '0;
    for (int j = 0; j < 4; j++) begin
      v = 8'h00;
      for (int t = 0; t < 8; t++) v = v ^ gf_mul(RS_M[j][t], kw[8*t +: 8], RS_POLY);
      s[8*j +: 8] = v;
    end
    return s;
  endfunction

endpackage

@@ src/twofish_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module twofish_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 20
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ src/twofish_h.sv @@
// Twofish h function: key-dependent q-permutation layers followed by MDS.
// Depends on twofish_pkg.
`timescale 1ns / 1ps
module twofish_h (
  input  logic [31:0]         x_i,
  input  twofish_pkg::word4_t list_i,
  input  logic [1:0]          key_size_i,
  output logic [31:0]         z_o
);
  import twofish_pkg::*;

  logic [7:0] y [4];
  logic [7:0] v;

  always_comb begin
    for (int j = 0; j < 4; j++) y[j] = x_i[8*j +: 8];
    if (key_size_i[1]) begin
      y[0] = qperm(1'b1, y[0]) ^ list_i[3][7:0];
      y[1] = qperm(1'b0, y[1]) ^ list_i[3][15:8];
      y[2] = qperm(1'b0, y[2]) ^ list_i[3][23:16];
      y[3] = qperm(1'b1, y[3]) ^ list_i[3][31:24];
    end
    if (key_size_i != 2'd0) begin
      y[0] = qperm(1'b1, y[0]) ^ list_i[2][7:0];
      y[1] = qperm(1'b1, y[1]) ^ list_i[2][15:8];
      y[2] = qperm(1'b0, y[2]) ^ list_i[2][23:16];
      y[3] = qperm(1'b0, y[3]) ^ list_i[2][31:24];
    end
    y[0] = qperm(1'b1, qperm(1'b0, qperm(1'b0, y[0]) ^ list_i[1][7:0]) ^ list_i[0][7:0]);
    y[1] = qperm(1'b0, qperm(1'b0, qperm(1'b1, y[1]) ^ list_i[1][15:8]) ^ list_i[0][15:8]);
    y[2] = qperm(1'b1, qperm(1'b1, qperm(1'b0, y[2]) ^ list_i[1][23:16]) ^ list_i[0][23:16]);
    y[3] = qperm(1'b0, qperm(1'b1, qperm(1'b1, y[3]) ^ list_i[1][31:24]) ^ list_i[0][31:24]);
    for (int i = 0; i < 4; i++) begin
      v = 8'h00;
      for (int j = 0; j < 4; j++) v = v ^ gf_mul(MDS_M[i][j], y[j], MDS_POLY);
      z_o[8*i +: 8] = v;
    end
  end

endmodule

@@ src/twofish_block_encrypt_core.sv @@
// Twofish block encryption core: sequencer, key schedule and round datapath.
// Depends on twofish_pkg, twofish_h, twofish_ram and the assertion macro header.
//
// One 128-bit block is encrypted under the 128/192/256-bit key held in the
// configuration registers. A single h-function unit is shared by the key
// schedule and the rounds: a round has the steps ST_RND_A and ST_RND_B (one h
// evaluation per cycle). A block passes through input whitening (ST_WIN0 to
// ST_WIN2), the rounds and output whitening (ST_WOUT0 to ST_WOUT2), the
// whitening set by the one read port of the subkey memory. After any
// configuration write the first block also waits for schedule expansion: an
// ST_RS step per S-box key word (2, 3 or 4) and ST_KS_A, ST_KS_B for each of
// the 20 subkey pairs. The input is not ready while a block is in work; a
// finished result waits in the output register while the next block is taken.
`timescale 1ns / 1ps
`include "twofish_block_encrypt_core_assert.svh"
module twofish_block_encrypt_core (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [2:0]   cfg_idx_i,
  input  logic [63:0]  cfg_data_i,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [127:0] s_axis_tdata,  // block_low [63:0], block_high [127:64]
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [127:0] m_axis_tdata   // cipher_low [63:0], cipher_high [127:64]
);
  import twofish_pkg::*;

  state_e state_q, state_d;
  logic [PAIR_AW-1:0] cnt_q, cnt_d;
  logic sched_valid_q, sched_valid_d;
  logic out_valid_q, out_valid_d;

  logic [63:0] key_q [4];
  logic [1:0]  key_size_q;
  word4_t      sbox_q;
  logic [31:0] w_q [4];
  logic [31:0] t_q;
  logic [63:0] out_lo_q;
  logic [127:0] out_q;

  logic [1:0]  kw_last;
  logic [31:0] h_x, h_z;
  word4_t      h_list;
  word4_t      even_w, odd_w;
  logic [7:0]  sk_byte;
  logic        ram_we;
  logic [PAIR_AW-1:0] ram_raddr;
  logic [63:0] ram_wdata, ram_rdata;
  logic [31:0] ks_b, ks_sum0, ks_sum1;
  logic [31:0] f0, f1, rd_t1;
  logic        in_fire, out_free;

  assign in_fire  = s_axis_tvalid && s_axis_tready;
  assign out_free = !out_valid_q || m_axis_tready;
  assign kw_last  = (key_size_q == 2'd0) ? 2'd1 : (key_size_q == 2'd1) ? 2'd2 : 2'd3;
  assign sk_byte  = {2'b00, cnt_q, 1'b0};

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      even_w[i] = key_q[i][31:0];
      odd_w[i]  = key_q[i][63:32];
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    sched_valid_d = sched_valid_q;
    unique case (state_q)
      ST_IDLE: begin
        cnt_d = '0;
        if (in_fire) state_d = sched_valid_q ? ST_WIN0 : ST_RS;
      end
      ST_RS: begin
        if (cnt_q[1:0] == kw_last) begin
          state_d = ST_KS_A;
          cnt_d   = '0;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_KS_A: state_d = ST_KS_B;
      ST_KS_B: begin
        if (cnt_q == PAIR_AW'(SUBKEY_PAIRS - 1)) begin
          state_d = ST_WIN0;
          sched_valid_d = 1'b1;
        end else begin
          state_d = ST_KS_A;
          cnt_d   = cnt_q + 1'b1;
        end
      end
      ST_WIN0: state_d = ST_WIN1;
      ST_WIN1: state_d = ST_WIN2;
      ST_WIN2: begin
        state_d = ST_RND_A;
        cnt_d   = '0;
      end
      ST_RND_A: state_d = ST_RND_B;
      ST_RND_B: begin
        if (cnt_q == PAIR_AW'(ROUND_COUNT - 1)) begin
          state_d = ST_WOUT0;
        end else begin
          state_d = ST_RND_A;
          cnt_d   = cnt_q + 1'b1;
        end
      end
      ST_WOUT0: state_d = ST_WOUT1;
      ST_WOUT1: state_d = ST_WOUT2;
      ST_WOUT2: if (out_free) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
    if (cfg_we_i) sched_valid_d = 1'b0;
  end

  // outputs of the sequencer
  always_comb begin
    h_x       = w_q[0];
    h_list    = sbox_q;
    ram_we    = 1'b0;
    ram_raddr = '0;
    unique case (state_q)
      ST_KS_A: begin
        h_x    = {4{sk_byte}};
        h_list = even_w;
      end
      ST_KS_B: begin
        h_x    = {4{sk_byte | 8'h01}};
        h_list = odd_w;
        ram_we = 1'b1;
      end
      ST_WIN1:  ram_raddr = PAIR_AW'(1);
      ST_RND_A: ram_raddr = cnt_q + PAIR_AW'(4);
      ST_RND_B: begin
        h_x       = {w_q[1][23:0], w_q[1][31:24]};
        ram_raddr = cnt_q + PAIR_AW'(4);
      end
      ST_WOUT0: ram_raddr = PAIR_AW'(2);
      ST_WOUT1, ST_WOUT2: ram_raddr = PAIR_AW'(3);
      default:  ram_raddr = '0;
    endcase
  end

  twofish_h u_h (
    .x_i        (h_x),
    .list_i     (h_list),
    .key_size_i (key_size_q),
    .z_o        (h_z)
  );

  assign ks_b      = {h_z[23:0], h_z[31:24]};
  assign ks_sum0   = t_q + ks_b;
  assign ks_sum1   = t_q + {ks_b[30:0], 1'b0};
  assign ram_wdata = {ks_sum1[22:0], ks_sum1[31:23], ks_sum0};

  twofish_ram #(
    .WIDTH (64),
    .DEPTH (SUBKEY_PAIRS)
  ) u_subkeys (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (cnt_q),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign rd_t1 = h_z;
  assign f0    = t_q + rd_t1 + ram_rdata[31:0];
  assign f1    = t_q + {rd_t1[30:0], 1'b0} + ram_rdata[63:32];

  assign out_valid_d = (state_q == ST_WOUT2 && out_free) ? 1'b1 :
                       (m_axis_tready ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      cnt_q         <= '0;
      sched_valid_q <= 1'b0;
      out_valid_q   <= 1'b0;
      key_q         <= '{default: '0};
      key_size_q    <= 2'd0;
    end else begin
      state_q       <= state_d;
      cnt_q         <= cnt_d;
      sched_valid_q <= sched_valid_d;
      out_valid_q   <= out_valid_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_KEY0:     key_q[0]   <= cfg_data_i;
          CFG_KEY1:     key_q[1]   <= cfg_data_i;
          CFG_KEY2:     key_q[2]   <= cfg_data_i;
          CFG_KEY3:     key_q[3]   <= cfg_data_i;
          CFG_KEY_SIZE: key_size_q <= cfg_data_i[1:0];
          default:      ;
        endcase
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          w_q[0] <= s_axis_tdata[31:0];
          w_q[1] <= s_axis_tdata[63:32];
          w_q[2] <= s_axis_tdata[95:64];
          w_q[3] <= s_axis_tdata[127:96];
        end
      end
      ST_RS: sbox_q[kw_last - cnt_q[1:0]] <= rs_word(key_q[cnt_q[1:0]]);
      ST_KS_A, ST_RND_A: t_q <= h_z;
      ST_WIN1: begin
        w_q[0] <= w_q[0] ^ ram_rdata[31:0];
        w_q[1] <= w_q[1] ^ ram_rdata[63:32];
      end
      ST_WIN2: begin
        w_q[2] <= w_q[2] ^ ram_rdata[31:0];
        w_q[3] <= w_q[3] ^ ram_rdata[63:32];
      end
      ST_RND_B: begin
        w_q[0] <= {(w_q[2][0] ^ f0[0]), (w_q[2][31:1] ^ f0[31:1])};
        w_q[1] <= {w_q[3][30:0], w_q[3][31]} ^ f1;
        w_q[2] <= w_q[0];
        w_q[3] <= w_q[1];
      end
      ST_WOUT1: out_lo_q <= {w_q[3] ^ ram_rdata[63:32], w_q[2] ^ ram_rdata[31:0]};
      ST_WOUT2: begin
        if (out_free) out_q <= {w_q[1] ^ ram_rdata[63:32], w_q[0] ^ ram_rdata[31:0], out_lo_q};
      end
      default: ;
    endcase
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q;

  `TF_ASSERT_NXT(a_busy_after_transfer, clk_i, rst_ni, in_fire, !s_axis_tready)
  `TF_ASSERT_NXT(a_cfg_stales_schedule, clk_i, rst_ni, cfg_we_i, !sched_valid_q)
  `TF_ASSERT_NXT(a_last_round_exits, clk_i, rst_ni,
                 state_q == ST_RND_B && cnt_q == PAIR_AW'(ROUND_COUNT - 1),
                 state_q == ST_WOUT0)
  `TF_ASSERT_IMP(a_rounds_need_schedule, clk_i, rst_ni,
                 state_q == ST_RND_A || state_q == ST_RND_B, sched_valid_q || cfg_we_i
                 || $past(cfg_we_i))

endmodule

@@ verif/twofish_block_encrypt_core_test.sv @@
// Self-checking testbench for the Twofish block encryption core.
// Depends on twofish_pkg (register indexes) and twofish_block_encrypt_core.
`timescale 1ns / 1ps
module twofish_block_encrypt_core_test;
  import twofish_pkg::*;

  localparam int N_RANDOM = 1630;
  localparam longint CYCLE_LIMIT = 2000000;

  logic         clk_i, rst_ni;
  logic         cfg_we_i;
  logic [2:0]   cfg_idx_i;
  logic [63:0]  cfg_data_i;
  logic         s_axis_tvalid, s_axis_tready;
  logic [127:0] s_axis_tdata;
  logic         m_axis_tvalid, m_axis_tready;
  logic [127:0] m_axis_tdata;

  twofish_block_encrypt_core u_top (.*);

  // predictor copy of key registers and expanded schedule
  logic [63:0] key_reg [4];
  logic [1:0]  size_reg;
  logic [31:0] subkey [40];
  logic [31:0] sbox_word [4];
  logic [127:0] cipher_q [$];
  int  mismatches;
  longint cycles;
  bit  hold_off;
  bit  sending;

  localparam logic [7:0] MDS_T [4][4] = '{'{8'h01,8'hEF,8'h5B,8'h5B},
    '{8'h5B,8'hEF,8'hEF,8'h01},'{8'hEF,8'h5B,8'h01,8'hEF},'{8'hEF,8'h01,8'hEF,8'h5B}};
  localparam logic [7:0] RS_T [4][8] = '{
    '{8'h01,8'hA4,8'h55,8'h87,8'h5A,8'h58,8'hDB,8'h9E},
    '{8'hA4,8'h56,8'h82,8'hF3,8'h1E,8'hC6,8'h68,8'hE5},
    '{8'h02,8'hA1,8'hFC,8'hC1,8'h47,8'hAE,8'h3D,8'h19},
    '{8'hA4,8'h55,8'h87,8'h5A,8'h58,8'hDB,8'h9E,8'h03}};
  localparam logic [3:0] PERM [2][4][16] = '{
    '{'{4'h8,4'h1,4'h7,4'hD,4'h6,4'hF,4'h3,4'h2,4'h0,4'hB,4'h5,4'h9,4'hE,4'hC,4'hA,4'h4},
      '{4'hE,4'hC,4'hB,4'h8,4'h1,4'h2,4'h3,4'h5,4'hF,4'h4,4'hA,4'h6,4'h7,4'h0,4'h9,4'hD},
      '{4'hB,4'hA,4'h5,4'hE,4'h6,4'hD,4'h9,4'h0,4'hC,4'h8,4'hF,4'h3,4'h2,4'h4,4'h7,4'h1},
      '{4'hD,4'h7,4'hF,4'h4,4'h1,4'h2,4'h6,4'hE,4'h9,4'hB,4'h3,4'h0,4'h8,4'h5,4'hC,4'hA}},
    '{'{4'h2,4'h8,4'hB,4'hD,4'hF,4'h7,4'h6,4'hE,4'h3,4'h1,4'h9,4'h4,4'h0,4'hA,4'hC,4'h5},
      '{4'h1,4'hE,4'h2,4'hB,4'h4,4'hC,4'h3,4'h7,4'h6,4'hD,4'hA,4'h5,4'hF,4'h9,4'h0,4'h8},
      '{4'h4,4'hC,4'h7,4'h5,4'h1,4'h6,4'h9,4'hA,4'h0,4'hE,4'hD,4'h8,4'h2,4'hB,4'h3,4'hF},
      '{4'hB,4'h9,4'h5,4'h1,4'hC,4'h3,4'hD,4'hE,4'h6,4'h4,4'h7,4'hF,4'h2,4'h0,4'h8,4'hA}}};

  function automatic logic [7:0] field_mul(logic [7:0] a, logic [7:0] b, logic [7:0] red);
    logic [7:0] acc;
    acc = '0;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) acc ^= a;
      a = a[7] ? ({a[6:0], 1'b0} ^ red) : {a[6:0], 1'b0};
    end
    return acc;
  endfunction

  function automatic logic [7:0] q_box(int w, logic [7:0] x);
    logic [3:0] a, b, a2, b2;
    a = x[7:4] ^ x[3:0];
    b = x[7:4] ^ {x[0], x[3:1]} ^ {x[4], 3'b0};
    a2 = PERM[w][0][a];
    b2 = PERM[w][1][b];
    a = a2 ^ b2;
    b = a2 ^ {b2[0], b2[3:1]} ^ {a2[0], 3'b0};
    return {PERM[w][3][b], PERM[w][2][a]};
  endfunction

  function automatic logic [31:0] h_mix(logic [31:0] x, logic [31:0] l [4], int k);
    logic [7:0] y [4];
    logic [31:0] z;
    logic [7:0] v;
    for (int j = 0; j < 4; j++) y[j] = x[8*j +: 8];
    if (k >= 4) begin
      y[0] = q_box(1, y[0]) ^ l[3][7:0];   y[1] = q_box(0, y[1]) ^ l[3][15:8];
      y[2] = q_box(0, y[2]) ^ l[3][23:16]; y[3] = q_box(1, y[3]) ^ l[3][31:24];
    end
    if (k >= 3) begin
      y[0] = q_box(1, y[0]) ^ l[2][7:0];   y[1] = q_box(1, y[1]) ^ l[2][15:8];
      y[2] = q_box(0, y[2]) ^ l[2][23:16]; y[3] = q_box(0, y[3]) ^ l[2][31:24];
    end
    y[0] = q_box(1, q_box(0, q_box(0, y[0]) ^ l[1][7:0]) ^ l[0][7:0]);
    y[1] = q_box(0, q_box(0, q_box(1, y[1]) ^ l[1][15:8]) ^ l[0][15:8]);
    y[2] = q_box(1, q_box(1, q_box(0, y[2]) ^ l[1][23:16]) ^ l[0][23:16]);
    y[3] = q_box(0, q_box(1, q_box(1, y[3]) ^ l[1][31:24]) ^ l[0][31:24]);
    z = '0;
    for (int i = 0; i < 4; i++) begin
      v = '0;
      for (int j = 0; j < 4; j++) v ^= field_mul(MDS_T[i][j], y[j], 8'h69);
      z[8*i +: 8] = v;
    end
    return z;
  endfunction

  function automatic int key_len();
    return (size_reg == 2'd0) ? 2 : (size_reg == 2'd1) ? 3 : 4;
  endfunction

  function automatic logic [31:0] rol(logic [31:0] x, int n);
    return (x << n) | (x >> (32 - n));
  endfunction

  task automatic expand_key();
    logic [31:0] ev [4], od [4];
    logic [31:0] a, b, s;
    logic [7:0] v;
    int k;
    k = key_len();
    for (int i = 0; i < 4; i++) begin
      ev[i] = key_reg[i][31:0];
      od[i] = key_reg[i][63:32];
    end
    for (int i = 0; i < k; i++) begin
      s = '0;
      for (int j = 0; j < 4; j++) begin
        v = '0;
        for (int t = 0; t < 8; t++) v ^= field_mul(RS_T[j][t], key_reg[i][8*t +: 8], 8'h4D);
        s[8*j +: 8] = v;
      end
      sbox_word[k-1-i] = s;
    end
    for (int i = 0; i < 20; i++) begin
      a = h_mix(32'(2*i) * 32'h01010101, ev, k);
      b = rol(h_mix(32'(2*i+1) * 32'h01010101, od, k), 8);
      subkey[2*i] = a + b;
      subkey[2*i+1] = rol(a + {b[30:0], 1'b0}, 9);
    end
  endtask

  function automatic logic [127:0] encrypt_block(logic [127:0] p);
    logic [31:0] w [4];
    logic [31:0] t0, t1, f0, f1, n0, n1;
    int k;
    k = key_len();
    for (int i = 0; i < 4; i++) w[i] = p[32*i +: 32] ^ subkey[i];
    for (int r = 0; r < 16; r++) begin
      t0 = h_mix(w[0], sbox_word, k);
      t1 = h_mix(rol(w[1], 8), sbox_word, k);
      f0 = t0 + t1 + subkey[2*r+8];
      f1 = t0 + {t1[30:0], 1'b0} + subkey[2*r+9];
      n0 = w[2] ^ f0;
      n0 = {n0[0], n0[31:1]};
      n1 = rol(w[3], 1) ^ f1;
      w[2] = w[0]; w[3] = w[1]; w[0] = n0; w[1] = n1;
    end
    return {w[1] ^ subkey[7], w[0] ^ subkey[6], w[3] ^ subkey[5], w[2] ^ subkey[4]};
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("twofish_block_encrypt_core test failed");
        $finish;
      end
    end
  end

  // receiver with random stalls and one long hold-off
  initial begin
    int gap;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) begin
        if (cipher_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected transfer %h", m_axis_tdata);
        end else begin
          if (cipher_q[0][63:0] !== m_axis_tdata[63:0] ||
              cipher_q[0][127:64] !== m_axis_tdata[127:64]) begin
            mismatches++;
            if (mismatches <= 10)
              $display("cipher mismatch: expected %h actual %h", cipher_q[0], m_axis_tdata);
          end
          void'(cipher_q.pop_front());
        end
      end
      if (hold_off) begin
        m_axis_tready <= 1'b0;
        repeat (400) @(posedge clk_i);
        hold_off = 1'b0;
      end
      gap = $urandom_range(0, 99);
      m_axis_tready <= (gap < 70) || (gap > 97 && $urandom_range(0, 1) == 0);
    end
  end

  task automatic write_reg(cfg_idx_e idx, logic [63:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    if (idx == CFG_KEY_SIZE) size_reg = val[1:0];
    else key_reg[idx] = val;
  endtask

  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (cipher_q.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  task automatic load_key(logic [63:0] k0, k1, k2, k3, logic [1:0] sz);
    settle();
    write_reg(CFG_KEY0, k0);
    write_reg(CFG_KEY1, k1);
    write_reg(CFG_KEY2, k2);
    write_reg(CFG_KEY3, k3);
    write_reg(CFG_KEY_SIZE, {62'd0, sz});
    cfg_we_i <= 1'b0;
    expand_key();
  endtask

  task automatic send_block(logic [127:0] p, logic [127:0] known, bit has_known);
    int g;
    g = $urandom_range(0, 19);
    if (g > 9) begin
      s_axis_tvalid <= 1'b0;
      if (g > 15) repeat ($urandom_range(20, 90)) @(posedge clk_i);
      else repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= p;
    cipher_q.push_back(has_known ? known : encrypt_block(p));
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  typedef struct {
    logic [127:0] plain;
    logic [127:0] cipher;
    bit           known;
  } vector_t;

  vector_t directed [10];
  logic [63:0] kx [4];

  initial begin
    mismatches = 0;
    hold_off = 1'b0;
    for (int i = 0; i < 4; i++) key_reg[i] = '0;
    size_reg = '0;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0; cfg_idx_i = CFG_KEY0; cfg_data_i = '0;
    s_axis_tvalid = 1'b0; s_axis_tdata = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    expand_key();
    // published zero key, zero plaintext vector
    directed[0] = '{128'h5AC3E82A_2FECBFB6_322C12F6_5C9F589F, 128'h0, 1'b0};
    directed[0] = '{128'h0, 128'h5AC3E82A_2FECBFB6_322C12F6_5C9F589F, 1'b1};
    directed[1] = '{{128{1'b1}}, 128'h0, 1'b0};
    directed[2] = '{128'h1, 128'h0, 1'b0};
    directed[3] = '{{1'b1, 127'h0}, 128'h0, 1'b0};
    directed[4] = '{{64'h0, {64{1'b1}}}, 128'h0, 1'b0};
    directed[5] = '{{{64{1'b1}}, 64'h0}, 128'h0, 1'b0};
    directed[6] = '{{32{4'hA}}, 128'h0, 1'b0};
    directed[7] = '{{32{4'h5}}, 128'h0, 1'b0};
    directed[8] = '{128'h0123456789ABCDEF_FEDCBA9876543210, 128'h0, 1'b0};
    directed[9] = '{128'h0, 128'h0, 1'b0};
    foreach (directed[i]) send_block(directed[i].plain, directed[i].cipher, directed[i].known);
    // all-ones key at each size code, three included, then bytes in unused registers
    for (int sz = 0; sz < 4; sz++) begin
      load_key({64{1'b1}}, {64{1'b1}}, {64{1'b1}}, {64{1'b1}}, 2'(sz));
      send_block(128'h0, 128'h0, 1'b0);
      send_block({128{1'b1}}, 128'h0, 1'b0);
    end
    load_key(64'h0, 64'h0, {64{1'b1}}, 64'h1234, 2'd0);
    send_block(128'h0, 128'h0, 1'b0);
    send_block({$urandom, $urandom, $urandom, $urandom}, 128'h0, 1'b0);
    // out-of-range register index is ignored
    settle();
    cfg_we_i <= 1'b1; cfg_idx_i <= 3'd7; cfg_data_i <= {64{1'b1}};
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    send_block(128'h0, 128'h0, 1'b0);
    for (int i = 0; i < N_RANDOM; i++) begin
      if (i % 200 == 0) begin
        for (int j = 0; j < 4; j++) kx[j] = {$urandom, $urandom};
        load_key(kx[0], kx[1], kx[2], kx[3], 2'($urandom_range(0, 3)));
      end
      if (i == 700) hold_off = 1'b1;
      if (i >= 700 && i < 730) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {$urandom, $urandom, $urandom, $urandom};
        @(posedge clk_i);
        cipher_q.push_back(encrypt_block(s_axis_tdata));
        while (!s_axis_tready) @(posedge clk_i);
      end else
        send_block({$urandom, $urandom, $urandom, $urandom}, 128'h0, 1'b0);
    end
    settle();
    if (mismatches == 0) $display("twofish_block_encrypt_core test passed");
    else $display("twofish_block_encrypt_core test failed");
    $finish;
  end
endmodule

@@ sim.f @@
+incdir+src
src/twofish_pkg.sv
src/twofish_ram.sv
src/twofish_h.sv
src/twofish_block_encrypt_core.sv
verif/twofish_block_encrypt_core_test.sv
